// File: hw/rtl/nnbs_pkg.sv
package nnbs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LB_DEPTH  = 4096;
    localparam int LB_ADDR_W = $clog2(LB_DEPTH);
    localparam int ACC_W     = 35;
    localparam int SDIM_W    = 13;
    localparam int DDIM_W    = 19;
    localparam int SCALE_W   = 32;
    localparam int PIXEL_W   = 24;
    localparam int STRIDE_W  = 15;
    localparam int OFFSET_W  = 26;
    localparam int ROW_OUT_W = 12;
    localparam int PRODUCT_W = SDIM_W + STRIDE_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [OFFSET_W-1:0] HEADER_BYTES = OFFSET_W'(54);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE = 3'd4;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_REQUEST = 2'd0;
    localparam kind_t KIND_PIXEL   = 2'd1;
    localparam kind_t KIND_PAD     = 2'd2;

    typedef logic [1:0] phase_t;
    localparam phase_t PH_REQUEST = 2'd0;
    localparam phase_t PH_PIXEL   = 2'd1;
    localparam phase_t PH_PAD     = 2'd2;

    typedef logic [ACC_W-1:0] acc_t;

    // add the reciprocal once, saturating at dim << FRAC_BITS
    function automatic acc_t sat_add(acc_t acc, logic [SDIM_W-1:0] dim,
                                     logic [SCALE_W-1:0] inv);
        acc_t cap;
        acc_t sum;
        cap = acc_t'(dim) << FRAC_BITS;
        sum = acc + acc_t'(inv);
        return (sum > cap) ? cap : sum;
    endfunction

    // integer part of the accumulator, clamped to dim - 1
    function automatic logic [SDIM_W-1:0] clamp_index(acc_t acc, logic [SDIM_W-1:0] dim);
        logic [ACC_W-FRAC_BITS-1:0] idx;
        idx = acc[ACC_W-1:FRAC_BITS];
        return (idx >= (ACC_W-FRAC_BITS)'(dim)) ? dim - SDIM_W'(1) : idx[SDIM_W-1:0];
    endfunction

endpackage

// File: hw/rtl/nearest_neighbor_bmp_scaler_unit.sv
// Nearest-neighbour BMP scaler: load transfers (mode 0) write one source pixel into a
// 4096-entry line buffer and give no result; advance transfers (mode 1) each give one
// element of the resized stream: a row request with source row and file offset, the
// row's pixels, then its zero pad bytes. One transfer is taken every clock unless an advance
// waits in the input register for the m_ channel to be free; a result reaches the m_ channel
// through the input register and then the result register; the result register and the
// registered line buffer read are loaded at the same edge. Configuration writes are taken
// at any time and should only be made while the block is idle.
module nearest_neighbor_bmp_scaler_unit (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nnbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nnbs_pkg::SCALE_W-1:0]      cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [nnbs_pkg::LB_ADDR_W-1:0]    s_column,
    input  logic [7:0]                        s_red_in,
    input  logic [7:0]                        s_green_in,
    input  logic [7:0]                        s_blue_in,

    output logic                              m_valid,
    input  logic                              m_ready,
    output nnbs_pkg::kind_t                   m_kind,
    output logic [nnbs_pkg::ROW_OUT_W-1:0]    m_source_row,
    output logic [nnbs_pkg::OFFSET_W-1:0]     m_row_offset,
    output logic [7:0]                        m_red_out,
    output logic [7:0]                        m_green_out,
    output logic [7:0]                        m_blue_out,
    output logic                              m_end_of_row,
    output logic                              m_end_of_frame
);
    import nnbs_pkg::*;

    logic [SDIM_W-1:0]    src_width_reg, src_height_reg;
    logic [DDIM_W-1:0]    dst_width_reg, dst_height_reg;
    logic [SCALE_W-1:0]   inv_scale_reg;

    logic                 in_valid_reg;
    logic                 in_mode_reg;
    logic [LB_ADDR_W-1:0] in_column_reg;
    logic [PIXEL_W-1:0]   in_pixel_reg;

    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [ROW_OUT_W-1:0] out_src_row_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic                 out_eor_reg, out_eof_reg;
    logic [PIXEL_W-1:0]   pix_reg;

    phase_t               phase_reg, phase_next;
    logic [DDIM_W-1:0]    out_row_reg, out_row_next;
    logic [DDIM_W-1:0]    out_col_reg, out_col_next;
    logic [1:0]           pads_left_reg, pads_left_next;
    acc_t                 row_acc_reg, row_acc_next;
    acc_t                 col_acc_reg, col_acc_next;

    logic [PIXEL_W-1:0]   line_mem [LB_DEPTH];

    logic [SDIM_W-1:0]    sw, sh;
    logic [DDIM_W-1:0]    dw, dh;
    logic                 out_free, stage_go, do_adv, do_load;
    logic [SDIM_W-1:0]    col_clamp, row_clamp;
    logic [LB_ADDR_W-1:0] rd_addr;
    logic [STRIDE_W-1:0]  stride;
    logic [PRODUCT_W-1:0] row_product;
    logic [1:0]           pad_dec;
    logic                 end_row;

    kind_t                kind_next;
    logic [ROW_OUT_W-1:0] src_row_next;
    logic [OFFSET_W-1:0]  offset_next;
    logic                 eor_next, eof_next;

    // zero dimensions act as one
    assign sw = (src_width_reg  == '0) ? SDIM_W'(1) : src_width_reg;
    assign sh = (src_height_reg == '0) ? SDIM_W'(1) : src_height_reg;
    assign dw = (dst_width_reg  == '0) ? DDIM_W'(1) : dst_width_reg;
    assign dh = (dst_height_reg == '0) ? DDIM_W'(1) : dst_height_reg;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || m_ready;
    assign stage_go = in_valid_reg && (in_mode_reg == MODE_LOAD || out_free);
    assign do_adv   = stage_go && in_mode_reg == MODE_ADVANCE;
    assign do_load  = stage_go && in_mode_reg == MODE_LOAD;
    assign s_ready  = !in_valid_reg || stage_go;

    assign col_clamp   = clamp_index(col_acc_reg, sw);
    assign row_clamp   = clamp_index(row_acc_reg, sh);
    assign rd_addr     = col_clamp[LB_ADDR_W-1:0];
    assign stride      = (STRIDE_W'(sw) << 1) + STRIDE_W'(sw) + STRIDE_W'(sw[1:0]);
    assign row_product = PRODUCT_W'(row_clamp) * PRODUCT_W'(stride);
    assign pad_dec     = pads_left_reg - ((pads_left_reg != 2'd0) ? 2'd1 : 2'd0);

    always_comb begin
        phase_next     = phase_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        pads_left_next = pads_left_reg;
        row_acc_next   = row_acc_reg;
        col_acc_next   = col_acc_reg;
        kind_next      = KIND_REQUEST;
        src_row_next   = '0;
        offset_next    = '0;
        eor_next       = 1'b0;
        eof_next       = 1'b0;
        end_row        = 1'b0;
        unique case (phase_reg)
            PH_PIXEL: begin
                kind_next = KIND_PIXEL;
                if ({1'b0, out_col_reg} + (DDIM_W+1)'(1) >= {1'b0, dw}) begin
                    pads_left_next = dw[1:0];
                    if (dw[1:0] != 2'd0) begin
                        phase_next = PH_PAD;
                    end else begin
                        end_row = 1'b1;
                    end
                end else begin
                    out_col_next = out_col_reg + DDIM_W'(1);
                    col_acc_next = sat_add(col_acc_reg, sw, inv_scale_reg);
                end
            end
            PH_PAD: begin
                kind_next      = KIND_PAD;
                pads_left_next = pad_dec;
                if (pad_dec == 2'd0) begin
                    end_row = 1'b1;
                end
            end
            default: begin
                kind_next    = KIND_REQUEST;
                src_row_next = row_clamp[ROW_OUT_W-1:0];
                offset_next  = row_product[OFFSET_W-1:0] + HEADER_BYTES;
                out_col_next = '0;
                col_acc_next = '0;
                phase_next   = PH_PIXEL;
            end
        endcase
        if (end_row) begin
            eor_next   = 1'b1;
            phase_next = PH_REQUEST;
            if ({1'b0, out_row_reg} + (DDIM_W+1)'(1) >= {1'b0, dh}) begin
                eof_next     = 1'b1;
                out_row_next = '0;
                row_acc_next = '0;
            end else begin
                out_row_next = out_row_reg + DDIM_W'(1);
                row_acc_next = sat_add(row_acc_reg, sh, inv_scale_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= SDIM_W'(1);
            src_height_reg <= SDIM_W'(1);
            dst_width_reg  <= DDIM_W'(1);
            dst_height_reg <= DDIM_W'(1);
            inv_scale_reg  <= SCALE_W'(1) << FRAC_BITS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:  src_width_reg  <= cfg_data[SDIM_W-1:0];
                CFG_SOURCE_HEIGHT: src_height_reg <= cfg_data[SDIM_W-1:0];
                CFG_DEST_WIDTH:    dst_width_reg  <= cfg_data[DDIM_W-1:0];
                CFG_DEST_HEIGHT:   dst_height_reg <= cfg_data[DDIM_W-1:0];
                CFG_INVERSE_SCALE: inv_scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_REQUEST;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            pads_left_reg <= '0;
            row_acc_reg   <= '0;
            col_acc_reg   <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (stage_go) begin
                in_valid_reg <= 1'b0;
            end
            if (do_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (do_adv) begin
                phase_reg     <= phase_next;
                out_row_reg   <= out_row_next;
                out_col_reg   <= out_col_next;
                pads_left_reg <= pads_left_next;
                row_acc_reg   <= row_acc_next;
                col_acc_reg   <= col_acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg   <= s_mode;
            in_column_reg <= s_column;
            in_pixel_reg  <= {s_red_in, s_green_in, s_blue_in};
        end
        if (do_adv) begin
            out_kind_reg    <= kind_next;
            out_src_row_reg <= src_row_next;
            out_offset_reg  <= offset_next;
            out_eor_reg     <= eor_next;
            out_eof_reg     <= eof_next;
        end
    end

    // line buffer
    always_ff @(posedge aclk) begin
        if (do_load) begin
            line_mem[in_column_reg] <= in_pixel_reg;
        end
        if (do_adv) begin
            pix_reg <= line_mem[rd_addr];
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_kind_reg;
    assign m_source_row   = out_src_row_reg;
    assign m_row_offset   = out_offset_reg;
    assign m_red_out      = (out_kind_reg == KIND_PIXEL) ? pix_reg[23:16] : 8'd0;
    assign m_green_out    = (out_kind_reg == KIND_PIXEL) ? pix_reg[15:8]  : 8'd0;
    assign m_blue_out     = (out_kind_reg == KIND_PIXEL) ? pix_reg[7:0]   : 8'd0;
    assign m_end_of_row   = out_eor_reg;
    assign m_end_of_frame = out_eof_reg;

endmodule

// File: test/nearest_neighbor_bmp_scaler_unit_tb.sv
`timescale 1ns / 100ps

module nearest_neighbor_bmp_scaler_unit_tb;

    import nnbs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIPE_SETTLE  = 4;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int RANDOM_SETS  = 12;
    localparam int ITEMS_PER_SET = 88;

    typedef struct packed {
        logic                 mode;
        logic [LB_ADDR_W-1:0] column;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
    } input_item_t;

    typedef struct packed {
        kind_t                kind;
        logic [ROW_OUT_W-1:0] source_row;
        logic [OFFSET_W-1:0]  row_offset;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic                 end_of_row;
        logic                 end_of_frame;
    } stream_elem_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SCALE_W-1:0]   cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_mode = 1'b0;
    logic [LB_ADDR_W-1:0] s_column = '0;
    logic [7:0]           s_red_in = '0;
    logic [7:0]           s_green_in = '0;
    logic [7:0]           s_blue_in = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    kind_t                m_kind;
    logic [ROW_OUT_W-1:0] m_source_row;
    logic [OFFSET_W-1:0]  m_row_offset;
    logic [7:0]           m_red_out;
    logic [7:0]           m_green_out;
    logic [7:0]           m_blue_out;
    logic                 m_end_of_row;
    logic                 m_end_of_frame;

    nearest_neighbor_bmp_scaler_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_column       (s_column),
        .s_red_in       (s_red_in),
        .s_green_in     (s_green_in),
        .s_blue_in      (s_blue_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_source_row   (m_source_row),
        .m_row_offset   (m_row_offset),
        .m_red_out      (m_red_out),
        .m_green_out    (m_green_out),
        .m_blue_out     (m_blue_out),
        .m_end_of_row   (m_end_of_row),
        .m_end_of_frame (m_end_of_frame)
    );

    input_item_t  input_items[$];
    stream_elem_t expected_elements[$];

    int  idle_pct = 18;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  loads_sent = 0;
    int  elements_checked = 0;
    int  register_writes = 0;
    bit  s_taken = 1'b0;

    // scaler state as seen from the stream
    logic [SDIM_W-1:0]  cfg_sw = SDIM_W'(1);
    logic [SDIM_W-1:0]  cfg_sh = SDIM_W'(1);
    logic [DDIM_W-1:0]  cfg_dw = DDIM_W'(1);
    logic [DDIM_W-1:0]  cfg_dh = DDIM_W'(1);
    logic [SCALE_W-1:0] cfg_inv = SCALE_W'(1) << FRAC_BITS;
    phase_t             ph = PH_REQUEST;
    int unsigned        out_row = 0;
    int unsigned        out_col = 0;
    int unsigned        pads_left = 0;
    acc_t               row_acc = '0;
    acc_t               col_acc = '0;
    logic [PIXEL_W-1:0] line_buffer [LB_DEPTH];
    bit                 written [LB_DEPTH];

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned at_least_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic acc_t step_acc(acc_t acc, int unsigned dim);
        acc_t cap;
        acc_t sum;
        cap = acc_t'(dim) << FRAC_BITS;
        sum = acc + acc_t'(cfg_inv);
        return (sum > cap) ? cap : sum;
    endfunction

    function automatic int unsigned clamp_src(acc_t acc, int unsigned dim);
        acc_t whole;
        whole = acc >> FRAC_BITS;
        return (whole >= acc_t'(dim)) ? dim - 1 : int'(whole);
    endfunction

    function automatic int unsigned pixel_column();
        return clamp_src(col_acc, at_least_one(cfg_sw)) % LB_DEPTH;
    endfunction

    function automatic void close_row(inout stream_elem_t el);
        el.end_of_row = 1'b1;
        if (out_row + 1 >= at_least_one(cfg_dh)) begin
            el.end_of_frame = 1'b1;
            out_row = 0;
            row_acc = '0;
        end else begin
            out_row++;
            row_acc = step_acc(row_acc, at_least_one(cfg_sh));
        end
        ph = PH_REQUEST;
    endfunction

    function automatic void scale_step(input input_item_t it, output bit has_result,
                                       output stream_elem_t el);
        int unsigned       sw;
        int unsigned       sh;
        int unsigned       dw;
        int unsigned       r;
        longint unsigned   stride;
        logic [PIXEL_W-1:0] px;
        sw = at_least_one(cfg_sw);
        sh = at_least_one(cfg_sh);
        dw = at_least_one(cfg_dw);
        el = '0;
        has_result = 1'b0;
        if (it.mode == MODE_LOAD) begin
            line_buffer[it.column] = {it.red, it.green, it.blue};
            written[it.column] = 1'b1;
            return;
        end
        has_result = 1'b1;
        case (ph)
            PH_PIXEL: begin
                px = line_buffer[pixel_column()];
                el.kind = KIND_PIXEL;
                el.red = px[23:16];
                el.green = px[15:8];
                el.blue = px[7:0];
                if (out_col + 1 >= dw) begin
                    pads_left = dw & 3;
                    if (pads_left != 0) begin
                        ph = PH_PAD;
                    end else begin
                        close_row(el);
                    end
                end else begin
                    out_col++;
                    col_acc = step_acc(col_acc, sw);
                end
            end
            PH_PAD: begin
                el.kind = KIND_PAD;
                if (pads_left > 0) begin
                    pads_left--;
                end
                if (pads_left == 0) begin
                    close_row(el);
                end
            end
            default: begin
                r = clamp_src(row_acc, sh);
                stride = 3 * longint'(sw) + (sw & 3);
                el.kind = KIND_REQUEST;
                el.source_row = r[ROW_OUT_W-1:0];
                el.row_offset = OFFSET_W'(64'(HEADER_BYTES) + 64'(r) * stride);
                out_col = 0;
                col_acc = '0;
                ph = PH_PIXEL;
            end
        endcase
    endfunction

    function automatic input_item_t make_item(logic mode, logic [LB_ADDR_W-1:0] column,
                                              logic [7:0] red, logic [7:0] green,
                                              logic [7:0] blue);
        input_item_t it;
        it.mode = mode;
        it.column = column;
        it.red = red;
        it.green = green;
        it.blue = blue;
        return it;
    endfunction

    function automatic void queue_item(input_item_t it);
        bit           has_result;
        stream_elem_t el;
        scale_step(it, has_result, el);
        if (has_result) begin
            expected_elements.push_back(el);
        end
        input_items.push_back(it);
        items_sent++;
        if (it.mode == MODE_LOAD) begin
            loads_sent++;
        end
    endfunction

    // a pixel is never read from a column that has not been loaded
    function automatic void send_item(input_item_t it);
        if (it.mode == MODE_ADVANCE && ph == PH_PIXEL && !written[pixel_column()]) begin
            queue_item(make_item(MODE_LOAD, LB_ADDR_W'(pixel_column()), 8'($urandom),
                                 8'($urandom), 8'($urandom)));
        end
        queue_item(it);
    endfunction

    function automatic void send_advances(int n);
        for (int i = 0; i < n; i++) begin
            send_item(make_item(MODE_ADVANCE, LB_ADDR_W'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom)));
        end
    endfunction

    function automatic logic [SDIM_W-1:0] pick_source_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return SDIM_W'(4096);
            2: return '1;
            3: return SDIM_W'($urandom);
            default: return SDIM_W'($urandom_range(48, 1));
        endcase
    endfunction

    function automatic logic [DDIM_W-1:0] pick_dest_dim(int unsigned most);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return DDIM_W'(409600);
            3: return DDIM_W'($urandom);
            default: return DDIM_W'($urandom_range(most, 1));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_inverse(int unsigned sw, int unsigned dw);
        longint unsigned ratio;
        ratio = (64'(sw) << FRAC_BITS) / dw;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return SCALE_W'(1) << FRAC_BITS;
            3: return SCALE_W'($urandom);
            4: return SCALE_W'(ratio);
            default: return SCALE_W'(ratio + $urandom_range(255));
        endcase
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SCALE_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        register_writes++;
        case (idx)
            CFG_SOURCE_WIDTH:  cfg_sw = data[SDIM_W-1:0];
            CFG_SOURCE_HEIGHT: cfg_sh = data[SDIM_W-1:0];
            CFG_DEST_WIDTH:    cfg_dw = data[DDIM_W-1:0];
            CFG_DEST_HEIGHT:   cfg_dh = data[DDIM_W-1:0];
            CFG_INVERSE_SCALE: cfg_inv = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [SDIM_W-1:0] sw, logic [SDIM_W-1:0] sh,
                                 logic [DDIM_W-1:0] dw, logic [DDIM_W-1:0] dh,
                                 logic [SCALE_W-1:0] inv);
        write_register(CFG_SOURCE_WIDTH, SCALE_W'(sw));
        write_register(CFG_SOURCE_HEIGHT, SCALE_W'(sh));
        write_register(CFG_DEST_WIDTH, SCALE_W'(dw));
        write_register(CFG_DEST_HEIGHT, SCALE_W'(dh));
        write_register(CFG_INVERSE_SCALE, inv);
    endtask

    // every transfer taken and every element back, then let the pipeline empty
    task automatic wait_idle();
        while (input_items.size() != 0 || s_valid || expected_elements.size() != 0)
            @(posedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        s_taken <= s_valid && s_ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin : drive_items
        input_item_t it;
        bit          present;
        if (aresetn && (!s_valid || s_taken)) begin
            present = input_items.size() != 0 && $urandom_range(99) >= idle_pct;
            if (present) begin
                it = input_items.pop_front();
                s_mode <= it.mode;
                s_column <= it.column;
                s_red_in <= it.red;
                s_green_in <= it.green;
                s_blue_in <= it.blue;
            end
            s_valid <= present;
        end
    end

    always @(negedge aclk) begin
        m_ready <= $urandom_range(99) >= idle_pct;
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_elements
        stream_elem_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_elements.size() == 0) begin
                $display("%0t: unexpected element, expected none, actual kind %0d",
                         $time, m_kind);
                fail_count++;
            end else begin
                want = expected_elements.pop_front();
                check_field("kind", want.kind, m_kind);
                check_field("source_row", want.source_row, m_source_row);
                check_field("row_offset", want.row_offset, m_row_offset);
                check_field("red_out", want.red, m_red_out);
                check_field("green_out", want.green, m_green_out);
                check_field("blue_out", want.blue, m_blue_out);
                check_field("end_of_row", want.end_of_row, m_end_of_row);
                check_field("end_of_frame", want.end_of_frame, m_end_of_frame);
                elements_checked++;
            end
        end
    end

    initial begin : stimulus
        logic [SDIM_W-1:0] sw;
        logic [SDIM_W-1:0] sh;
        logic [DDIM_W-1:0] dw;
        logic [DDIM_W-1:0] dh;
        int                drain_cycles;
        int unsigned       load_span;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: one pixel, one pad byte, end of frame, next frame
        send_item(make_item(MODE_LOAD, '0, 8'hFF, 8'h00, 8'hFF));
        send_item(make_item(MODE_LOAD, '1, 8'h00, 8'hFF, 8'h00));
        send_advances(4);
        wait_idle();

        // zero dimensions and zero scale behave as ones and row 0
        apply_setting('0, '0, '0, '0, '0);
        send_advances(3);
        wait_idle();

        // wide source with saturating scale, rows and columns clamp to the far edge
        apply_setting('1, '1, DDIM_W'(4), DDIM_W'(3), '1);
        send_item(make_item(MODE_LOAD, LB_ADDR_W'(4094), 8'h00, 8'h00, 8'h00));
        send_advances(7);
        wait_idle();

        // narrower rows mid-frame end the current row's pixels at the next pixel, then one pad byte
        write_register(CFG_DEST_WIDTH, SCALE_W'(1));
        send_advances(3);

        for (int p = 0; p < RANDOM_SETS; p++) begin
            wait_idle();
            idle_pct = (p == 5) ? 0 : 18;
            sw = pick_source_dim();
            sh = pick_source_dim();
            dw = pick_dest_dim(40);
            dh = pick_dest_dim(6);
            apply_setting(sw, sh, dw, dh, pick_inverse(at_least_one(sw), at_least_one(dw)));
            load_span = (at_least_one(sw) > LB_DEPTH) ? LB_DEPTH : at_least_one(sw);
            for (int k = 0; k < ITEMS_PER_SET; k++) begin
                if ((p == 3 || p == 8) && k == ITEMS_PER_SET / 2) begin
                    wait_idle();
                end
                if ($urandom_range(99) < 70) begin
                    send_advances(1);
                end else if ($urandom_range(1)) begin
                    send_item(make_item(MODE_LOAD, LB_ADDR_W'($urandom_range(load_span - 1)),
                                        8'($urandom), 8'($urandom), 8'($urandom)));
                end else begin
                    send_item(make_item(MODE_LOAD, LB_ADDR_W'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom)));
                end
            end
        end

        while (input_items.size() != 0 || s_valid) @(posedge aclk);
        drain_cycles = 0;
        while (expected_elements.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (PIPE_SETTLE) @(negedge aclk);
        if (expected_elements.size() != 0) begin
            $display("%0t: %0d expected elements never arrived, expected 0, actual %0d",
                     $time, expected_elements.size(), expected_elements.size());
            fail_count++;
        end

        $display("sent %0d transfers (%0d pixel loads), checked %0d stream elements",
                 items_sent, loads_sent, elements_checked);
        $display("%0d register writes over %0d settings incl. zero, wide and saturating cases",
                 register_writes, RANDOM_SETS + 3);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
